// File: hdl/srsr_pkg.sv
// Shared types, field widths and command codes for the sector ring sample recorder.
package srsr_pkg;

  localparam int CMD_W    = 3;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 24;
  localparam int SECTOR_W = 32;
  localparam int OFF_W    = 10;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 2;
  localparam int ACTION_W = 2;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 184;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int SECTOR_BYTES_DEF = 512;

  // Commands carried in tuser
  localparam logic [CMD_W-1:0] CMD_SAMPLE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FINALIZE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SNAPSHOT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OUTCOME  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd3;

  // Result action codes
  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STORE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_BASE_SECTOR  = 1'b0;
  localparam logic REG_RING_SECTORS = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           snapshot_index;
    logic                       ok_flag;
  } item_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] base_sector;
    logic [IDX_W-1:0]    ring_sectors;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [ACTION_W-1:0]        action;
    logic                       commit;
    logic [SECTOR_W-1:0]        sector;
    logic [OFF_W-1:0]           byte_offset;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [IDX_W-1:0]           filled_sectors;
    logic [CNT_W-1:0]           written_total;
    logic [CNT_W-1:0]           wraps;
    logic [CNT_W-1:0]           failures;
    logic                       is_ready;
  } result_t;

endpackage

// File: hdl/srsr_cfg.sv
// APB register file holding the ring base sector and ring length.
module srsr_cfg import srsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                wr_en;
  logic [SECTOR_W-1:0] base_sector;
  logic [IDX_W-1:0]    ring_sectors;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Decode on the word bit of the address
  always_ff @(posedge clk) begin
    if (rst) begin
      base_sector  <= '0;
      ring_sectors <= IDX_W'(1);
    end else if (wr_en) begin
      case (paddr[2])
        REG_BASE_SECTOR:  base_sector  <= pwdata;
        REG_RING_SECTORS: ring_sectors <= pwdata[IDX_W-1:0];
        default:          base_sector  <= base_sector;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_BASE_SECTOR:  prdata = base_sector;
      REG_RING_SECTORS: prdata = {{(APB_DW-IDX_W){1'b0}}, ring_sectors};
      default:          prdata = '0;
    endcase
  end

  assign cfg.base_sector  = base_sector;
  assign cfg.ring_sectors = ring_sectors;

endmodule

// File: hdl/srsr_core.sv
// Recorder state and the single-pass next-state and result logic for one item.
module srsr_core import srsr_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int FILL_W = $clog2(SECTOR_BYTES + 1);
  localparam logic [FILL_W:0]   SECTOR_LIMIT = (FILL_W + 1)'(SECTOR_BYTES);
  localparam logic [FILL_W-1:0] SECTOR_FULL  = FILL_W'(SECTOR_BYTES);

  logic [FILL_W-1:0] fill_bytes, fill_bytes_next;
  logic [IDX_W-1:0]  ring_index, ring_index_next;
  logic [CNT_W-1:0]  written_count, written_count_next;
  logic [CNT_W-1:0]  lap_count, lap_count_next;
  logic [CNT_W-1:0]  fail_count, fail_count_next;
  logic              ready_flag, ready_flag_next;
  logic              awaiting, awaiting_next;

  logic [IDX_W-1:0]  ring_len;
  logic [IDX_W-1:0]  valid_now;
  logic [IDX_W-1:0]  oldest;
  logic [IDX_W:0]    rel_sum;
  logic [IDX_W:0]    rel;
  logic [IDX_W:0]    idx_inc;
  logic [FILL_W:0]   fill_plus;
  logic [SECTOR_W-1:0] cur_sector;

  // Zero ring length behaves as one sector
  assign ring_len = (cfg.ring_sectors == '0) ? IDX_W'(1) : cfg.ring_sectors;

  assign valid_now = !ready_flag ? '0 :
                     (written_count < {{(CNT_W-IDX_W){1'b0}}, ring_len}) ?
                     written_count[IDX_W-1:0] : ring_len;

  // Snapshot mapping: oldest block, then compare-and-wrap
  assign oldest  = (written_count >= {{(CNT_W-IDX_W){1'b0}}, ring_len} &&
                    ring_index < ring_len) ? ring_index : '0;
  assign rel_sum = {1'b0, oldest} + {1'b0, item.snapshot_index};
  assign rel     = (rel_sum >= {1'b0, ring_len}) ? rel_sum - {1'b0, ring_len} : rel_sum;

  assign idx_inc    = {1'b0, ring_index} + (IDX_W + 1)'(1);
  assign fill_plus  = {1'b0, fill_bytes} + (FILL_W + 1)'(2);
  assign cur_sector = cfg.base_sector + {{(SECTOR_W-IDX_W){1'b0}}, ring_index};

  // Next state and result for the item in the input register
  always_comb begin
    fill_bytes_next    = fill_bytes;
    ring_index_next    = ring_index;
    written_count_next = written_count;
    lap_count_next     = lap_count;
    fail_count_next    = fail_count;
    ready_flag_next    = ready_flag;
    awaiting_next      = awaiting;

    result.status      = ready_flag ? ST_OK : ST_NOT_READY;
    result.action      = ACT_NONE;
    result.commit      = 1'b0;
    result.sector      = '0;
    result.byte_offset = '0;
    result.sample_out  = '0;

    case (item.cmd)
      CMD_START: begin
        fill_bytes_next    = '0;
        ring_index_next    = '0;
        written_count_next = '0;
        lap_count_next     = '0;
        fail_count_next    = '0;
        awaiting_next      = 1'b0;
        ready_flag_next    = item.ok_flag;
        result.status      = item.ok_flag ? ST_OK : ST_NOT_READY;
      end
      CMD_SAMPLE: begin
        if (!ready_flag) begin
          result.status = ST_NOT_READY;
        end else if (awaiting) begin
          result.status = ST_BUSY;
        end else begin
          result.sector      = cur_sector;
          result.action      = ACT_STORE;
          result.byte_offset = OFF_W'(fill_bytes);
          result.sample_out  = item.sample;
          if (fill_plus >= SECTOR_LIMIT) begin
            fill_bytes_next = SECTOR_FULL;
            result.commit   = 1'b1;
            awaiting_next   = 1'b1;
          end else begin
            fill_bytes_next = fill_plus[FILL_W-1:0];
          end
        end
      end
      CMD_FINALIZE: begin
        if (!ready_flag) begin
          result.status = ST_NOT_READY;
        end else if (awaiting) begin
          result.status = ST_BUSY;
        end else if (fill_bytes != '0) begin
          result.sector      = cur_sector;
          result.commit      = 1'b1;
          result.byte_offset = OFF_W'(fill_bytes);
          fill_bytes_next    = SECTOR_FULL;
          awaiting_next      = 1'b1;
        end
      end
      CMD_SNAPSHOT: begin
        if (ready_flag) begin
          if (item.snapshot_index >= valid_now) begin
            result.status = ST_RANGE;
          end else begin
            result.sector = cfg.base_sector + {{(SECTOR_W-IDX_W){1'b0}}, rel[IDX_W-1:0]};
            result.action = ACT_READ;
          end
        end
      end
      CMD_OUTCOME: begin
        if (awaiting) begin
          awaiting_next = 1'b0;
          if (item.ok_flag) begin
            written_count_next = written_count + CNT_W'(1);
            fill_bytes_next    = '0;
            result.status      = ST_OK;
            if (idx_inc >= {1'b0, ring_len}) begin
              ring_index_next = '0;
              lap_count_next  = lap_count + CNT_W'(1);
            end else begin
              ring_index_next = idx_inc[IDX_W-1:0];
            end
          end else begin
            ready_flag_next = 1'b0;
            fail_count_next = fail_count + CNT_W'(1);
            result.status   = ST_NOT_READY;
          end
        end
      end
      default: begin
        result.status = ready_flag ? ST_OK : ST_NOT_READY;
      end
    endcase

    // Totals reported after the step
    result.filled_sectors = !ready_flag_next ? '0 :
                            (written_count_next < {{(CNT_W-IDX_W){1'b0}}, ring_len}) ?
                            written_count_next[IDX_W-1:0] : ring_len;
    result.written_total  = written_count_next;
    result.wraps          = lap_count_next;
    result.failures       = fail_count_next;
    result.is_ready       = ready_flag_next;
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_bytes    <= '0;
      ring_index    <= '0;
      written_count <= '0;
      lap_count     <= '0;
      fail_count    <= '0;
      ready_flag    <= 1'b0;
      awaiting      <= 1'b0;
    end else if (fire) begin
      fill_bytes    <= fill_bytes_next;
      ring_index    <= ring_index_next;
      written_count <= written_count_next;
      lap_count     <= lap_count_next;
      fail_count    <= fail_count_next;
      ready_flag    <= ready_flag_next;
      awaiting      <= awaiting_next;
    end
  end

`ifndef SYNTHESIS
  a_wait_needs_fill: assert property (@(posedge clk) disable iff (rst)
    awaiting |-> fill_bytes == SECTOR_FULL)
    else $error("awaiting outcome with a partial sector");
  a_commit_sets_wait: assert property (@(posedge clk) disable iff (rst)
    fire && result.commit |=> awaiting)
    else $error("commit did not enter the outcome wait");
  a_index_wraps: assert property (@(posedge clk) disable iff (rst)
    fire && item.cmd == CMD_OUTCOME && awaiting && item.ok_flag &&
    ring_index_next == '0 |-> lap_count_next == lap_count + CNT_W'(1))
    else $error("ring index wrapped without counting");
`endif

endmodule

// File: hdl/sector_ring_sample_recorder.sv
// An accepted item is held in the input register, then its result in the result register, which drives m_tvalid.
// Throughput: one item per cycle while m_tready stays high; input register, single-pass logic, result register.
// Each stage holds when the stage after it is full and not being taken.
// Reset clears the stage valid flags, recorder state and both config registers
// (base 0, ring length 1); the block is not ready until a start item arrives.
module sector_ring_sample_recorder import srsr_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // sample, snapshot_index, ok_flag, zero pad
  input  logic [CMD_W-1:0]     s_tuser,  // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status, action, commit, sector, byte_offset, sample_out, filled_sectors,
  // written_total, wraps, failures, is_ready
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t res_comb;
  result_t res;
  logic    res_valid;
  logic    advance;
  logic    fire;
  logic    s_beat;

  srsr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srsr_core #(.SECTOR_BYTES(SECTOR_BYTES)) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (res_comb)
  );

  // Handshake between the two register stages
  assign advance  = !res_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign s_beat   = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_beat) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      in_item.cmd            <= s_tuser;
      in_item.sample         <= s_tdata[15:0];
      in_item.snapshot_index <= s_tdata[39:16];
      in_item.ok_flag        <= s_tdata[40];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_comb;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {res.is_ready, res.failures, res.wraps, res.written_total,
                     res.filled_sectors, res.sample_out, res.byte_offset, res.sector,
                     res.commit, res.action, res.status};

`ifndef SYNTHESIS
  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.commit |-> res.status == ST_OK)
    else $error("commit beat without ok status");
  a_read_no_commit: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.action == ACT_READ |-> res.status == ST_OK && !res.commit)
    else $error("read request beat carries commit or bad status");
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_item.cmd == CMD_START |=>
      res.written_total == '0 && res.failures == '0 && res.wraps == '0)
    else $error("start beat did not clear the counters");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && res_valid)
    else $error("input stalled with a free stage");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the sector ring sample recorder: directed table, then random phases.
module testbench;
  import srsr_pkg::*;

  localparam int SECTOR_BYTES = SECTOR_BYTES_DEF;
  localparam int RANDOM_ITEMS = 1850;
  localparam int N_PHASES     = 7;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int N_PLAN       = 26;

  // Codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] smp;
    logic [IDX_W-1:0]    idx;
    bit                  ok;
    logic [STATUS_W-1:0] st;
    logic [ACTION_W-1:0] act;
    bit                  rdy;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;  // sample, snapshot_index, ok_flag, zero pad
  logic [CMD_W-1:0]     s_tuser;  // cmd
  logic                 m_tvalid;
  logic                 m_tready;
  // status, action, commit, sector, byte_offset, sample_out, filled_sectors,
  // written_total, wraps, failures, is_ready
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  sector_ring_sample_recorder #(.SECTOR_BYTES(SECTOR_BYTES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Recorder state as the testbench predicts it
  logic [SECTOR_W-1:0] base_reg;
  logic [IDX_W-1:0]    ring_reg;
  logic [OFF_W-1:0]    fill_level;
  logic [IDX_W-1:0]    ring_pos;
  logic [CNT_W-1:0]    sectors_written;
  logic [CNT_W-1:0]    ring_wraps;
  logic [CNT_W-1:0]    write_failures;
  bit                  recorder_ready;
  bit                  outcome_pending;

  result_t   due_results[$];
  plan_row_t plan [N_PLAN];
  int        bad_beats;
  int        cycle_count;
  int        fed;
  bit        tx_calm;
  bit        rx_calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up on a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sector_ring_sample_recorder test failed");
      $finish;
    end
  end

  function automatic logic [24:0] ring_span();
    return (ring_reg == '0) ? 25'd1 : {1'b0, ring_reg};
  endfunction

  function automatic logic [IDX_W-1:0] live_blocks();
    logic [24:0] span;
    span = ring_span();
    if (!recorder_ready) return '0;
    return (sectors_written < span) ? sectors_written[IDX_W-1:0] : span[IDX_W-1:0];
  endfunction

  // Advance the predicted state by one item and return the reply it causes
  function automatic result_t predict_reply(item_t it);
    result_t     r;
    logic [24:0] span;
    logic [24:0] nxt;
    logic [24:0] rel;
    logic [IDX_W-1:0] oldest;
    r = '0;
    span = ring_span();
    r.status = recorder_ready ? ST_OK : ST_NOT_READY;
    case (it.cmd)
      CMD_START: begin
        fill_level = '0;
        ring_pos = '0;
        sectors_written = '0;
        ring_wraps = '0;
        write_failures = '0;
        outcome_pending = 1'b0;
        recorder_ready = it.ok_flag;
        r.status = it.ok_flag ? ST_OK : ST_NOT_READY;
      end
      CMD_SAMPLE, CMD_FINALIZE: begin
        if (!recorder_ready) begin
          r.status = ST_NOT_READY;
        end else if (outcome_pending) begin
          r.status = ST_BUSY;
        end else if (it.cmd == CMD_SAMPLE) begin
          r.sector = base_reg + SECTOR_W'(ring_pos);
          r.action = ACT_STORE;
          r.byte_offset = fill_level;
          r.sample_out = it.sample;
          if (int'(fill_level) + 2 >= SECTOR_BYTES) begin
            fill_level = OFF_W'(SECTOR_BYTES);
            r.commit = 1'b1;
            outcome_pending = 1'b1;
          end else begin
            fill_level = fill_level + OFF_W'(2);
          end
        end else if (fill_level != '0) begin
          r.sector = base_reg + SECTOR_W'(ring_pos);
          r.commit = 1'b1;
          r.byte_offset = fill_level;
          fill_level = OFF_W'(SECTOR_BYTES);
          outcome_pending = 1'b1;
        end
      end
      CMD_SNAPSHOT: begin
        if (recorder_ready) begin
          if (it.snapshot_index >= live_blocks()) begin
            r.status = ST_RANGE;
          end else begin
            oldest = (sectors_written >= span && ring_pos < span) ? ring_pos : '0;
            rel = {1'b0, oldest} + {1'b0, it.snapshot_index};
            if (rel >= span) rel = rel - span;
            r.sector = base_reg + SECTOR_W'(rel[IDX_W-1:0]);
            r.action = ACT_READ;
          end
        end
      end
      CMD_OUTCOME: begin
        if (outcome_pending) begin
          outcome_pending = 1'b0;
          if (it.ok_flag) begin
            nxt = {1'b0, ring_pos} + 25'd1;
            sectors_written = sectors_written + CNT_W'(1);
            if (nxt >= span) nxt = '0;
            ring_pos = nxt[IDX_W-1:0];
            if (nxt == '0) ring_wraps = ring_wraps + CNT_W'(1);
            fill_level = '0;
            r.status = ST_OK;
          end else begin
            recorder_ready = 1'b0;
            write_failures = write_failures + CNT_W'(1);
            r.status = ST_NOT_READY;
          end
        end
      end
      default: begin
      end
    endcase
    r.filled_sectors = live_blocks();
    r.written_total = sectors_written;
    r.wraps = ring_wraps;
    r.failures = write_failures;
    r.is_ready = recorder_ready;
    return r;
  endfunction

  function automatic result_t unpack_beat(logic [M_TDATA_W-1:0] d);
    result_t r;
    r.status         = d[1:0];
    r.action         = d[3:2];
    r.commit         = d[4];
    r.sector         = d[36:5];
    r.byte_offset    = d[46:37];
    r.sample_out     = d[62:47];
    r.filled_sectors = d[86:63];
    r.written_total  = d[118:87];
    r.wraps          = d[150:119];
    r.failures       = d[182:151];
    r.is_ready       = d[183];
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf({"st=%0d act=%0d commit=%0d sector=%h off=%0d smp=%h valid=%0d ",
                      "written=%0d wraps=%0d fails=%0d rdy=%0d"},
                     r.status, r.action, r.commit, r.sector, r.byte_offset, r.sample_out,
                     r.filled_sectors, r.written_total, r.wraps, r.failures, r.is_ready);
  endfunction

  function automatic item_t mk(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp,
                               logic [IDX_W-1:0] idx, bit ok);
    item_t it;
    it.cmd = cmd;
    it.sample = smp;
    it.snapshot_index = idx;
    it.ok_flag = ok;
    return it;
  endfunction

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = unpack_beat(m_tdata);
      if (due_results.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10) $display("unexpected result beat: %s", show(got));
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          bad_beats++;
          if (bad_beats <= 10) begin
            $display("result mismatch at cycle %0d", cycle_count);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  // Result side: random stalls, with calm stretches
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  // Send one item; returns at the edge where it was taken
  task automatic offer_item(item_t it, bit pinned = 1'b0, logic [STATUS_W-1:0] st = ST_OK,
                            logic [ACTION_W-1:0] act = ACT_NONE, bit rdy = 1'b0);
    int gap;
    result_t r;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {7'b0, it.ok_flag, it.snapshot_index, it.sample};
    s_tuser  <= it.cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    r = predict_reply(it);
    if (pinned) begin
      r.status = st;
      r.action = act;
      r.is_ready = rdy;
    end
    due_results.push_back(r);
    fed++;
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic await_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  // APB register write with a setup and an access phase; call at a falling edge
  task automatic write_reg(logic idx, logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_BASE_SECTOR) base_reg = val;
    else ring_reg = val[IDX_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 5) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, int'(live_blocks()) + 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One block of recording: samples, finalize, then the write outcome or a restart
  task automatic record_block(bit go_full);
    int n_samples;
    n_samples = go_full ? SECTOR_BYTES / 2 : $urandom_range(0, 5);
    for (int k = 0; k < n_samples && !outcome_pending; k++) begin
      offer_item(mk(CMD_SAMPLE, pick_sample(), $urandom, $urandom));
      if ($urandom_range(0, 15) == 0) offer_item(mk(CMD_SNAPSHOT, $urandom, pick_index(), $urandom));
    end
    if (!outcome_pending) offer_item(mk(CMD_FINALIZE, $urandom, $urandom, $urandom));
    // poke the block while it waits for the outcome
    if (outcome_pending && $urandom_range(0, 7) == 0) begin
      offer_item(mk($urandom_range(0, 1) ? CMD_SAMPLE : CMD_FINALIZE, $urandom, $urandom, $urandom));
      offer_item(mk(CMD_SNAPSHOT, $urandom, pick_index(), $urandom));
    end
    if ($urandom_range(0, 29) == 0)
      offer_item(mk(CMD_START, $urandom, $urandom, 1'b1));
    else
      offer_item(mk(CMD_OUTCOME, $urandom, $urandom, $urandom_range(0, 19) != 0));
    repeat ($urandom_range(0, 2)) offer_item(mk(CMD_SNAPSHOT, $urandom, pick_index(), $urandom));
  endtask

  initial begin
    logic [SECTOR_W-1:0] phase_base [N_PHASES];
    logic [APB_DW-1:0]   phase_ring [N_PHASES];
    logic [CMD_W-1:0]    noise_cmd;
    bit                  need_full;
    int                  target;

    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_SAMPLE;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst      = 1'b1;
    bad_beats = 0;
    cycle_count = 0;
    fed = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Predicted reset state
    base_reg = '0;
    ring_reg = 24'd1;
    fill_level = '0;
    ring_pos = '0;
    sectors_written = '0;
    ring_wraps = '0;
    write_failures = '0;
    recorder_ready = 1'b0;
    outcome_pending = 1'b0;

    plan = '{
      '{CMD_SAMPLE,   16'h7FFF, 24'h0,      1'b0, ST_NOT_READY, ACT_NONE,  1'b0},
      '{CMD_FINALIZE, 16'h0,    24'h0,      1'b0, ST_NOT_READY, ACT_NONE,  1'b0},
      '{CMD_SNAPSHOT, 16'h0,    24'h0,      1'b0, ST_NOT_READY, ACT_NONE,  1'b0},
      '{CMD_OUTCOME,  16'h0,    24'h0,      1'b1, ST_NOT_READY, ACT_NONE,  1'b0},
      '{CMD_UNUSED7,  16'hFFFF, 24'hFFFFFF, 1'b1, ST_NOT_READY, ACT_NONE,  1'b0},
      '{CMD_START,    16'h0,    24'h0,      1'b0, ST_NOT_READY, ACT_NONE,  1'b0},
      '{CMD_START,    16'h0,    24'h0,      1'b1, ST_OK,        ACT_NONE,  1'b1},
      '{CMD_FINALIZE, 16'h0,    24'h0,      1'b0, ST_OK,        ACT_NONE,  1'b1},
      '{CMD_SNAPSHOT, 16'h0,    24'h0,      1'b0, ST_RANGE,     ACT_NONE,  1'b1},
      '{CMD_SAMPLE,   16'h7FFF, 24'h0,      1'b0, ST_OK,        ACT_STORE, 1'b1},
      '{CMD_SAMPLE,   16'h8000, 24'h0,      1'b0, ST_OK,        ACT_STORE, 1'b1},
      '{CMD_SAMPLE,   16'hFFFF, 24'h0,      1'b0, ST_OK,        ACT_STORE, 1'b1},
      '{CMD_FINALIZE, 16'h0,    24'h0,      1'b0, ST_OK,        ACT_NONE,  1'b1},
      '{CMD_SAMPLE,   16'h0001, 24'h0,      1'b0, ST_BUSY,      ACT_NONE,  1'b1},
      '{CMD_FINALIZE, 16'h0,    24'h0,      1'b0, ST_BUSY,      ACT_NONE,  1'b1},
      '{CMD_SNAPSHOT, 16'h0,    24'h0,      1'b0, ST_RANGE,     ACT_NONE,  1'b1},
      '{CMD_OUTCOME,  16'h0,    24'h0,      1'b1, ST_OK,        ACT_NONE,  1'b1},
      '{CMD_OUTCOME,  16'h0,    24'h0,      1'b1, ST_OK,        ACT_NONE,  1'b1},
      '{CMD_SNAPSHOT, 16'h0,    24'h0,      1'b0, ST_OK,        ACT_READ,  1'b1},
      '{CMD_SNAPSHOT, 16'h0,    24'hFFFFFF, 1'b0, ST_RANGE,     ACT_NONE,  1'b1},
      '{CMD_SAMPLE,   16'h0000, 24'h0,      1'b0, ST_OK,        ACT_STORE, 1'b1},
      '{CMD_FINALIZE, 16'h0,    24'h0,      1'b0, ST_OK,        ACT_NONE,  1'b1},
      '{CMD_OUTCOME,  16'h0,    24'h0,      1'b0, ST_NOT_READY, ACT_NONE,  1'b0},
      '{CMD_SAMPLE,   16'h1234, 24'h0,      1'b0, ST_NOT_READY, ACT_NONE,  1'b0},
      '{CMD_START,    16'h0,    24'h0,      1'b1, ST_OK,        ACT_NONE,  1'b1},
      '{CMD_UNUSED5,  16'h5555, 24'hAAAAAA, 1'b0, ST_OK,        ACT_NONE,  1'b1}
    };

    // Ring settings per random phase: zero length, extremes, and a shrink without restart
    phase_base = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, $urandom,
                   32'hFFFF_FFFF, $urandom, 32'h8000_0000};
    phase_ring = '{32'd0, 32'h00FF_FFFF, 32'd2, 32'd1, 32'd5,
                   $urandom_range(3, 9), 32'hFF00_0004};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part on a small ring that straddles the top of the sector space
    write_reg(REG_BASE_SECTOR, 32'hFFFF_FFFE);
    write_reg(REG_RING_SECTORS, 32'd3);
    for (int i = 0; i < N_PLAN; i++)
      offer_item(mk(plan[i].cmd, plan[i].smp, plan[i].idx, plan[i].ok),
                 1'b1, plan[i].st, plan[i].act, plan[i].rdy);
    await_results();
    repeat (4) @(negedge clk);

    // Random phases
    need_full = 1'b1;
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_BASE_SECTOR, phase_base[p]);
      write_reg(REG_RING_SECTORS, phase_ring[p]);
      target = N_PLAN + (p + 1) * RANDOM_ITEMS / N_PHASES;
      while (fed < target) begin
        if ($urandom_range(0, 99) < 6) begin
          noise_cmd = $urandom_range(0, 7);
          if (noise_cmd == CMD_START && $urandom_range(0, 3) != 0) noise_cmd = CMD_SNAPSHOT;
          offer_item(mk(noise_cmd, $urandom, $urandom, $urandom));
        end else if (!recorder_ready) begin
          offer_item(mk(CMD_START, $urandom, $urandom, $urandom_range(0, 7) != 0));
        end else begin
          record_block(need_full || $urandom_range(0, 24) == 0);
          need_full = 1'b0;
        end
        if ($urandom_range(0, 59) == 0) await_results();
      end
      await_results();
      repeat (4) @(negedge clk);
    end

    repeat (8) @(negedge clk);
    if (bad_beats == 0 && due_results.size() == 0) begin
      $display("sector_ring_sample_recorder test passed");
    end else begin
      $display("sector_ring_sample_recorder test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/srsr_pkg.sv
hdl/srsr_cfg.sv
hdl/srsr_core.sv
hdl/sector_ring_sample_recorder.sv
tb/testbench.sv
